// ===== src/reorder_reassembly_tracker_macros.svh =====
// Assertion macros for the reorder reassembly tracker.
`ifndef REORDER_REASSEMBLY_TRACKER_MACROS_SVH
`define REORDER_REASSEMBLY_TRACKER_MACROS_SVH

`ifndef SYNTHESIS
// Check an implication in the same cycle.
`define RRT_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("rrt assertion failed");
// Check an implication whose consequent is due in the cycle after the antecedent.
`define RRT_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("rrt assertion failed");
`else
`define RRT_ASSERT_IMP(lbl, ante, cons)
`define RRT_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

// ===== src/rrt_pkg.sv =====
package rrt_pkg;

  localparam int POS_W    = 13;
  localparam int PART_W   = 12;
  localparam int WIN_W    = 12;
  localparam int CFG_W    = 13;
  localparam int ROW_BITS = 32;
  localparam int OFF_W    = 5;
  localparam int RUN_W    = 6;

  localparam logic [1:0] MODE_BEGIN   = 2'd0;
  localparam logic [1:0] MODE_ARRIVE  = 2'd1;
  localparam logic [1:0] MODE_REQUEST = 2'd2;

  localparam logic CFG_TOTAL  = 1'b0;
  localparam logic CFG_WINDOW = 1'b1;

  localparam logic [WIN_W-1:0] WINDOW_RESET = 12'd150;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PART_WR,
    ST_WALK_RD,
    ST_WALK_CHK
  } state_t;

  typedef struct packed {
    logic [POS_W-1:0] pos;
    logic             stop;
  } scan_res_t;

  function automatic logic [RUN_W-1:0] trailing_ones(input logic [ROW_BITS-1:0] x);
    logic [RUN_W-1:0] n;
    logic             hit;
    n   = RUN_W'(ROW_BITS);
    hit = 1'b0;
    for (int i = 0; i < ROW_BITS; i++) begin
      if (!hit && !x[i]) begin
        n   = RUN_W'(i);
        hit = 1'b1;
      end
    end
    return n;
  endfunction

endpackage

// ===== src/rrt_ram.sv =====
module rrt_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 128
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== src/rrt_scan.sv =====
module rrt_scan (
  input  logic [rrt_pkg::ROW_BITS-1:0] row_data,
  input  logic [rrt_pkg::POS_W-1:0]    pos,
  input  logic [rrt_pkg::POS_W-1:0]    total,
  output rrt_pkg::scan_res_t           res
);

  logic [rrt_pkg::OFF_W-1:0]    off;
  logic [rrt_pkg::ROW_BITS-1:0] shifted;
  logic [rrt_pkg::RUN_W-1:0]    run;
  logic [rrt_pkg::POS_W-1:0]    np;
  logic                         end_row;

  always_comb begin
    off     = pos[rrt_pkg::OFF_W-1:0];
    shifted = row_data >> off;
    run     = rrt_pkg::trailing_ones(shifted);
    np      = pos + rrt_pkg::POS_W'(run);
    end_row = (rrt_pkg::RUN_W'(off) + run) == rrt_pkg::RUN_W'(rrt_pkg::ROW_BITS);
    if (np >= total) begin
      res.pos  = total;
      res.stop = 1'b1;
    end else begin
      res.pos  = np;
      res.stop = !end_row;
    end
  end

endmodule

// ===== src/reorder_reassembly_tracker.sv =====
// Channel   Handshake           Payload
// input     start / busy        in_mode, in_part_number
// result    out_valid (strobe)  out_duplicate .. out_done_res
// config    cfg_we              cfg_index, cfg_wdata
//
// Begin, mode 3, ignored and out-of-range items: result in the cycle after start.
// Arrival reads the part's row and writes it back with the part's bit set, then walks in
// order from the write pointer; a request searches from its start. Each row of 32 parts
// visited is read in ST_WALK_RD and checked in ST_WALK_CHK; a walk at or past total reads no row.
// Reset (synchronous rst_n) clears control state and all row valid flops.
// Results cannot be stalled; busy holds off new items while an arrival or request is processed.
`include "reorder_reassembly_tracker_macros.svh"

module reorder_reassembly_tracker #(
  parameter int MAX_PARTS = 4096
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  logic [1:0]                   in_mode,
  input  logic [rrt_pkg::PART_W-1:0]   in_part_number,
  output logic                         out_valid,
  output logic                         out_duplicate,
  output logic                         out_out_of_range,
  output logic [rrt_pkg::POS_W-1:0]    out_write_pointer,
  output logic [rrt_pkg::POS_W-1:0]    out_released_count,
  output logic                         out_complete,
  output logic                         out_request_valid,
  output logic [rrt_pkg::PART_W-1:0]   out_request_part,
  output logic                         out_done_res,
  input  logic                         cfg_we,
  input  logic                         cfg_index,
  input  logic [rrt_pkg::CFG_W-1:0]    cfg_wdata
);

  localparam int STORE_PARTS = (MAX_PARTS > 4096) ? 4096 : MAX_PARTS;
  localparam int ROWS  = (STORE_PARTS + rrt_pkg::ROW_BITS - 1) / rrt_pkg::ROW_BITS;
  localparam int ROW_W = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam logic [rrt_pkg::POS_W-1:0] LIMIT = rrt_pkg::POS_W'(ROWS * rrt_pkg::ROW_BITS);

  rrt_pkg::state_t state_r, state_nxt;

  logic [rrt_pkg::POS_W-1:0]  cfg_total_r;
  logic [rrt_pkg::WIN_W-1:0]  cfg_window_r;
  logic [rrt_pkg::POS_W-1:0]  ptr_r, ptr_nxt;
  logic                       open_r, open_nxt;
  logic                       complete_r, complete_nxt;
  logic [ROWS-1:0]            row_valid_r, row_valid_nxt;
  logic [rrt_pkg::POS_W-1:0]  pos_r, pos_nxt;
  logic [1:0]                 mode_r, mode_nxt;
  logic                       dup_r, dup_nxt;

  logic                       ov_r, ov_nxt;
  logic                       o_dup_r, o_dup_nxt;
  logic                       o_oor_r, o_oor_nxt;
  logic [rrt_pkg::POS_W-1:0]  o_wp_r, o_wp_nxt;
  logic [rrt_pkg::POS_W-1:0]  o_rel_r, o_rel_nxt;
  logic                       o_cmp_r, o_cmp_nxt;
  logic                       o_rv_r, o_rv_nxt;
  logic [rrt_pkg::PART_W-1:0] o_rp_r, o_rp_nxt;
  logic                       o_done_r, o_done_nxt;

  logic [rrt_pkg::POS_W-1:0]    total;
  logic [rrt_pkg::POS_W-1:0]    part_pos;
  logic [rrt_pkg::POS_W-1:0]    req_start;
  logic [rrt_pkg::POS_W:0]      win_end;
  logic [rrt_pkg::POS_W-1:0]    rd_pos;
  logic [ROW_W-1:0]             cur_row;
  logic [rrt_pkg::ROW_BITS-1:0] row_masked;
  logic                         ram_we;
  logic [rrt_pkg::ROW_BITS-1:0] ram_wdata;
  logic [rrt_pkg::ROW_BITS-1:0] ram_rdata;
  logic                         fin;
  logic [rrt_pkg::POS_W-1:0]    fin_pos;
  rrt_pkg::scan_res_t           scan_res;

  assign total = ({4'b0, cfg_total_r} > 17'(MAX_PARTS)) ? rrt_pkg::POS_W'(MAX_PARTS)
                                                         : cfg_total_r;
  assign part_pos   = {1'b0, in_part_number};
  assign win_end    = {1'b0, ptr_r} + {2'b0, cfg_window_r};
  assign cur_row    = pos_r[ROW_W+rrt_pkg::OFF_W-1:rrt_pkg::OFF_W];
  assign row_masked = row_valid_r[cur_row] ? ram_rdata : '0;

  always_comb begin
    if (part_pos == total) begin
      req_start = ptr_r;
    end else begin
      req_start = part_pos;
    end
    if (win_end < {1'b0, req_start}) begin
      req_start = ptr_r;
    end
  end

  rrt_ram #(
    .WIDTH (rrt_pkg::ROW_BITS),
    .DEPTH (ROWS)
  ) u_map (
    .clk   (clk),
    .we    (ram_we),
    .waddr (cur_row),
    .wdata (ram_wdata),
    .raddr (rd_pos[ROW_W+rrt_pkg::OFF_W-1:rrt_pkg::OFF_W]),
    .rdata (ram_rdata)
  );

  rrt_scan u_scan (
    .row_data (row_masked),
    .pos      (pos_r),
    .total    (total),
    .res      (scan_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= rrt_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_total_r  <= '0;
      cfg_window_r <= rrt_pkg::WINDOW_RESET;
      ptr_r        <= '0;
      open_r       <= 1'b0;
      complete_r   <= 1'b0;
      row_valid_r  <= '0;
      ov_r         <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          rrt_pkg::CFG_TOTAL:  cfg_total_r  <= cfg_wdata;
          rrt_pkg::CFG_WINDOW: cfg_window_r <= cfg_wdata[rrt_pkg::WIN_W-1:0];
          default: ;
        endcase
      end
      ptr_r       <= ptr_nxt;
      open_r      <= open_nxt;
      complete_r  <= complete_nxt;
      row_valid_r <= row_valid_nxt;
      ov_r        <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pos_r    <= pos_nxt;
    mode_r   <= mode_nxt;
    dup_r    <= dup_nxt;
    o_dup_r  <= o_dup_nxt;
    o_oor_r  <= o_oor_nxt;
    o_wp_r   <= o_wp_nxt;
    o_rel_r  <= o_rel_nxt;
    o_cmp_r  <= o_cmp_nxt;
    o_rv_r   <= o_rv_nxt;
    o_rp_r   <= o_rp_nxt;
    o_done_r <= o_done_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    ptr_nxt       = ptr_r;
    open_nxt      = open_r;
    complete_nxt  = complete_r;
    row_valid_nxt = row_valid_r;
    pos_nxt       = pos_r;
    mode_nxt      = mode_r;
    dup_nxt       = dup_r;
    ov_nxt        = 1'b0;
    o_dup_nxt     = 1'b0;
    o_oor_nxt     = 1'b0;
    o_rel_nxt     = '0;
    o_rv_nxt      = 1'b0;
    o_rp_nxt      = '0;
    o_done_nxt    = 1'b0;
    rd_pos        = pos_r;
    ram_we        = 1'b0;
    ram_wdata     = row_masked;
    fin           = 1'b0;
    fin_pos       = pos_r;

    unique case (state_r)
      rrt_pkg::ST_IDLE: begin
        if (start) begin
          mode_nxt = in_mode;
          unique case (in_mode)
            rrt_pkg::MODE_BEGIN: begin
              row_valid_nxt = '0;
              ptr_nxt       = '0;
              open_nxt      = 1'b1;
              ov_nxt        = 1'b1;
            end
            rrt_pkg::MODE_ARRIVE: begin
              if (!open_r || part_pos >= total) begin
                o_oor_nxt = open_r;
                ov_nxt    = 1'b1;
              end else begin
                rd_pos    = part_pos;
                pos_nxt   = part_pos;
                state_nxt = rrt_pkg::ST_PART_WR;
              end
            end
            rrt_pkg::MODE_REQUEST: begin
              if (part_pos > total) begin
                o_oor_nxt = 1'b1;
                ov_nxt    = 1'b1;
              end else begin
                pos_nxt   = req_start;
                state_nxt = rrt_pkg::ST_WALK_RD;
              end
            end
            default: begin
              ov_nxt = 1'b1;
            end
          endcase
        end
      end
      rrt_pkg::ST_PART_WR: begin
        dup_nxt   = row_masked[pos_r[rrt_pkg::OFF_W-1:0]];
        ram_we    = 1'b1;
        ram_wdata = row_masked |
                    (rrt_pkg::ROW_BITS'(1) << pos_r[rrt_pkg::OFF_W-1:0]);
        row_valid_nxt[cur_row] = 1'b1;
        pos_nxt   = ptr_r;
        state_nxt = rrt_pkg::ST_WALK_RD;
      end
      rrt_pkg::ST_WALK_RD: begin
        if (pos_r >= total || pos_r >= LIMIT) begin
          fin     = 1'b1;
          fin_pos = pos_r;
        end else begin
          state_nxt = rrt_pkg::ST_WALK_CHK;
        end
      end
      rrt_pkg::ST_WALK_CHK: begin
        if (scan_res.stop) begin
          fin     = 1'b1;
          fin_pos = scan_res.pos;
        end else begin
          pos_nxt   = scan_res.pos;
          state_nxt = rrt_pkg::ST_WALK_RD;
        end
      end
      default: begin
        state_nxt = rrt_pkg::ST_IDLE;
      end
    endcase

    if (fin) begin
      state_nxt = rrt_pkg::ST_IDLE;
      ov_nxt    = 1'b1;
      if (mode_r == rrt_pkg::MODE_ARRIVE) begin
        ptr_nxt   = fin_pos;
        o_rel_nxt = fin_pos - ptr_r;
        o_dup_nxt = dup_r;
        if (fin_pos >= total) begin
          complete_nxt = 1'b1;
        end
      end else if (fin_pos >= total) begin
        o_done_nxt = 1'b1;
      end else begin
        o_rv_nxt = 1'b1;
        o_rp_nxt = fin_pos[rrt_pkg::PART_W-1:0];
      end
    end

    o_wp_nxt  = ptr_nxt;
    o_cmp_nxt = complete_nxt;
  end

  assign busy               = (state_r != rrt_pkg::ST_IDLE);
  assign out_valid          = ov_r;
  assign out_duplicate      = o_dup_r;
  assign out_out_of_range   = o_oor_r;
  assign out_write_pointer  = o_wp_r;
  assign out_released_count = o_rel_r;
  assign out_complete       = o_cmp_r;
  assign out_request_valid  = o_rv_r;
  assign out_request_part   = o_rp_r;
  assign out_done_res       = o_done_r;

  `RRT_ASSERT_IMP(a_no_strobe_while_busy, busy, !out_valid)
  `RRT_ASSERT_IMP(a_request_flags_excl, out_valid, !(out_request_valid && out_done_res))
  `RRT_ASSERT_IMP(a_ptr_within_store, 1'b1, ptr_r <= LIMIT)
  `RRT_ASSERT_NEXT(a_part_write_then_walk, state_r == rrt_pkg::ST_PART_WR,
                   state_r == rrt_pkg::ST_WALK_RD)

endmodule
